// ===== src/ipid_pkg.sv =====
// Shared widths, register indexes, sequencer states and saturation helper for the PID unit.
package ipid_pkg;

   localparam int ERR_W  = 16;   // error sample and gain width
   localparam int WORD_W = 32;   // time, integral, drive and product width
   localparam int QUO_W  = 17;   // signed derivative quotient width
   localparam int SUM_W  = 34;   // exact width of the three-term sum
   localparam int CNT_W  = 5;    // serial step counter width

   typedef enum logic [2:0] {
      CSR_KP             = 3'd0,
      CSR_KI             = 3'd1,
      CSR_KD             = 3'd2,
      CSR_SAMPLE_PERIOD  = 3'd3,
      CSR_INTEGRAL_UPPER = 3'd4,
      CSR_INTEGRAL_LOWER = 3'd5,
      CSR_DRIVE_UPPER    = 3'd6,
      CSR_DRIVE_LOWER    = 3'd7
   } csr_index_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CHECK = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_MULD  = 8'b0000_1000,
      ST_SUM1  = 8'b0001_0000,
      ST_SUM2  = 8'b0010_0000,
      ST_CLAMP = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   // Clamp to the upper limit first, then raise to the lower limit, so a
   // lower limit above the upper one wins.
   function automatic logic [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v,
                                                  input logic [WORD_W-1:0] hi,
                                                  input logic [WORD_W-1:0] lo);
      logic signed [SUM_W-1:0] hi_x;
      logic signed [SUM_W-1:0] lo_x;
      logic signed [SUM_W-1:0] r;
      hi_x = $signed({{(SUM_W-WORD_W){hi[WORD_W-1]}}, hi});
      lo_x = $signed({{(SUM_W-WORD_W){lo[WORD_W-1]}}, lo});
      r = v;
      if (r > hi_x) begin
         r = hi_x;
      end
      if (r < lo_x) begin
         r = lo_x;
      end
      return r[WORD_W-1:0];
   endfunction

endpackage

// ===== src/integer_pid_controller_unit.sv =====
// Integer PID controller with integral and output saturation, bit-serial datapath.
//
// Usage: an input transfer on the req_ channel carries an error sample and a
// millisecond timestamp. Every accepted transfer produces exactly one result
// transfer on the rsp_ channel: the controller drive in rsp_tdata and, in
// rsp_tuser, a flag that is set when a new update was computed. An update is
// due when the wrapped time since the last update reaches the sample period;
// otherwise the held drive comes back with the flag clear.
// Sequencing: a due item goes from the check state through the 16-step
// restoring divider (which runs the proportional and integral multiplies
// beside it) and the 17-step derivative multiply, all one bit per cycle, then
// the sum and clamp states to the output; an item not due goes straight from
// check to output. New items are taken only in idle. Gains and limits must be
// written through the csr_ port while the unit is idle; this is not enforced.
// Reset (synchronous, active high) restores the register defaults, clears the
// integral, the previous error, the last update time and the held drive, and
// empties the result register. When the receiver stalls, a finished result
// waits in the result register while the next item is accepted and computed;
// that item then waits in the final state until the register is free.
module integer_pid_controller_unit
   import ipid_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Input channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // [15:0] error_sample, [47:16] now_ms
   // Result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WORD_W-1:0]    rsp_tdata,   // [31:0] drive
   output logic                 rsp_tuser,   // [0] fresh
   // Configuration write port
   input  logic                 csr_we,
   input  logic [2:0]           csr_addr,
   input  logic [WORD_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [ERR_W-1:0]  kp_ff, ki_ff, kd_ff, period_ff;
   logic [WORD_W-1:0] int_upper_ff, int_lower_ff, drive_upper_ff, drive_lower_ff;

   // Controller state kept between items
   logic [WORD_W-1:0] integral_acc_ff;
   logic [ERR_W-1:0]  last_error_ff;
   logic [WORD_W-1:0] last_update_ff;
   logic [WORD_W-1:0] held_drive_ff;

   // Sequencer
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;

   // Captured item
   logic [ERR_W-1:0]  err_ff;
   logic [WORD_W-1:0] now_ff;
   logic              due_ff;

   // Restoring divider: remainder, dividend that fills with quotient bits,
   // divisor and sign of the difference.
   logic [ERR_W-1:0]  rem_ff, dvd_ff, dvsr_ff;
   logic              neg_ff;

   // Shift-add multipliers: serial operand, shifting multiplicand, accumulator
   logic [ERR_W-1:0]  err_sr_ff;
   logic [WORD_W-1:0] pmc_ff, imc_ff, p_acc_ff, i_acc_ff;
   logic [QUO_W-1:0]  q_sr_ff;
   logic [WORD_W-1:0] dmc_ff, d_acc_ff;

   // Wide sums
   logic [WORD_W:0]   isum_ff;
   logic [SUM_W-1:0]  sum_ff;

   // Result register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_data_ff;
   logic              rsp_user_ff;

   // Combinational helpers
   logic              req_fire, out_free, out_load;
   logic [WORD_W-1:0] elapsed;
   logic              due_in;
   logic [ERR_W:0]    diff;
   logic [ERR_W:0]    diff_mag;
   logic [ERR_W+1:0]  div_trial;
   logic              mul_last;
   logic [WORD_W-1:0] p_acc_in, i_acc_in, d_acc_in;
   logic [QUO_W-1:0]  q_signed;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = (state_ff == ST_OUT) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      // Due test uses wrapping subtraction of the timestamps.
      elapsed  = now_ff - last_update_ff;
      due_in   = (elapsed >= {{(WORD_W-ERR_W){1'b0}}, period_ff});
      // Derivative numerator and its magnitude; the magnitude fits in 16 bits.
      diff     = {err_ff[ERR_W-1], err_ff} - {last_error_ff[ERR_W-1], last_error_ff};
      diff_mag = diff[ERR_W] ? (~diff + 1'b1) : diff;
      // One restoring division step: shift in the next dividend bit, try to subtract.
      div_trial = {1'b0, rem_ff, dvd_ff[ERR_W-1]} - {2'b00, dvsr_ff};
      // The last serial bit of a two's complement operand has negative weight.
      mul_last = (cnt_ff == CNT_W'(ERR_W - 1));
      p_acc_in = p_acc_ff;
      i_acc_in = i_acc_ff;
      if (err_sr_ff[0]) begin
         p_acc_in = mul_last ? (p_acc_ff - pmc_ff) : (p_acc_ff + pmc_ff);
         i_acc_in = mul_last ? (i_acc_ff - imc_ff) : (i_acc_ff + imc_ff);
      end
      d_acc_in = d_acc_ff;
      if (q_sr_ff[0]) begin
         d_acc_in = (cnt_ff == CNT_W'(QUO_W - 1)) ? (d_acc_ff - dmc_ff)
                                                  : (d_acc_ff + dmc_ff);
      end
      // Quotient with the sign of the difference, truncated toward zero.
      q_signed = neg_ff ? (~{1'b0, dvd_ff} + 1'b1) : {1'b0, dvd_ff};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_CHECK;
         ST_CHECK: state_in = due_in ? ST_DIV : ST_OUT;
         ST_DIV:   if (cnt_ff == CNT_W'(ERR_W)) state_in = ST_MULD;
         ST_MULD:  if (cnt_ff == CNT_W'(QUO_W - 1)) state_in = ST_SUM1;
         ST_SUM1:  state_in = ST_SUM2;
         ST_SUM2:  state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         kp_ff           <= '0;
         ki_ff           <= '0;
         kd_ff           <= '0;
         period_ff       <= ERR_W'(10);
         int_upper_ff    <= {1'b0, {(WORD_W-1){1'b1}}};
         int_lower_ff    <= {1'b1, {(WORD_W-1){1'b0}}};
         drive_upper_ff  <= {1'b0, {(WORD_W-1){1'b1}}};
         drive_lower_ff  <= {1'b1, {(WORD_W-1){1'b0}}};
         integral_acc_ff <= '0;
         last_error_ff   <= '0;
         last_update_ff  <= '0;
         held_drive_ff   <= '0;
      end else begin
         state_ff <= state_in;

         if (state_ff != state_in) begin
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_KP:             kp_ff          <= csr_wdata[ERR_W-1:0];
               CSR_KI:             ki_ff          <= csr_wdata[ERR_W-1:0];
               CSR_KD:             kd_ff          <= csr_wdata[ERR_W-1:0];
               CSR_SAMPLE_PERIOD:  period_ff      <= csr_wdata[ERR_W-1:0];
               CSR_INTEGRAL_UPPER: int_upper_ff   <= csr_wdata;
               CSR_INTEGRAL_LOWER: int_lower_ff   <= csr_wdata;
               CSR_DRIVE_UPPER:    drive_upper_ff <= csr_wdata;
               CSR_DRIVE_LOWER:    drive_lower_ff <= csr_wdata;
               default: ;
            endcase
         end

         // The integral is saturated once its sum is ready, first derivative step.
         if (state_ff == ST_MULD && cnt_ff == '0) begin
            integral_acc_ff <= sat_word($signed({isum_ff[WORD_W], isum_ff}),
                                        int_upper_ff, int_lower_ff);
         end

         if (state_ff == ST_CLAMP) begin
            held_drive_ff  <= sat_word($signed(sum_ff), drive_upper_ff, drive_lower_ff);
            last_error_ff  <= err_ff;
            last_update_ff <= now_ff;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff <= req_tdata[ERR_W-1:0];
         now_ff <= req_tdata[47:16];
      end

      case (state_ff)
         ST_CHECK: begin
            due_ff    <= due_in;
            neg_ff    <= diff[ERR_W];
            dvd_ff    <= diff_mag[ERR_W-1:0];
            rem_ff    <= '0;
            // A zero period divides by one.
            dvsr_ff   <= (period_ff == '0) ? ERR_W'(1) : period_ff;
            err_sr_ff <= err_ff;
            pmc_ff    <= {{(WORD_W-ERR_W){kp_ff[ERR_W-1]}}, kp_ff};
            imc_ff    <= {{(WORD_W-ERR_W){ki_ff[ERR_W-1]}}, ki_ff};
            p_acc_ff  <= '0;
            i_acc_ff  <= '0;
         end
         ST_DIV: begin
            if (cnt_ff < CNT_W'(ERR_W)) begin
               if (!div_trial[ERR_W+1]) begin
                  rem_ff <= div_trial[ERR_W-1:0];
                  dvd_ff <= {dvd_ff[ERR_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[ERR_W-2:0], dvd_ff[ERR_W-1]};
                  dvd_ff <= {dvd_ff[ERR_W-2:0], 1'b0};
               end
               p_acc_ff  <= p_acc_in;
               i_acc_ff  <= i_acc_in;
               err_sr_ff <= {1'b0, err_sr_ff[ERR_W-1:1]};
               pmc_ff    <= {pmc_ff[WORD_W-2:0], 1'b0};
               imc_ff    <= {imc_ff[WORD_W-2:0], 1'b0};
            end else begin
               isum_ff  <= {integral_acc_ff[WORD_W-1], integral_acc_ff}
                         + {i_acc_ff[WORD_W-1], i_acc_ff};
               q_sr_ff  <= q_signed;
               dmc_ff   <= {{(WORD_W-ERR_W){kd_ff[ERR_W-1]}}, kd_ff};
               d_acc_ff <= '0;
            end
         end
         ST_MULD: begin
            d_acc_ff <= d_acc_in;
            q_sr_ff  <= {1'b0, q_sr_ff[QUO_W-1:1]};
            dmc_ff   <= {dmc_ff[WORD_W-2:0], 1'b0};
         end
         ST_SUM1: begin
            sum_ff <= {{(SUM_W-WORD_W){p_acc_ff[WORD_W-1]}}, p_acc_ff}
                    + {{(SUM_W-WORD_W){integral_acc_ff[WORD_W-1]}}, integral_acc_ff};
         end
         ST_SUM2: begin
            sum_ff <= sum_ff + {{(SUM_W-WORD_W){d_acc_ff[WORD_W-1]}}, d_acc_ff};
         end
         default: ;
      endcase

      if (out_load) begin
         rsp_data_ff <= held_drive_ff;
         rsp_user_ff <= due_ff;
      end
   end

   // The divide phase never runs past its extra setup step.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(ERR_W)))
      else $error("divide phase overran its step count");

   // A finished division leaves a remainder below the divisor.
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULD) |-> (rem_ff < dvsr_ff))
      else $error("division remainder not below divisor");

   // With ordered limits, the new drive lies within them.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP && $signed(drive_lower_ff) <= $signed(drive_upper_ff))
      |=> ($signed(held_drive_ff) <= $signed($past(drive_upper_ff)) &&
           $signed(held_drive_ff) >= $signed($past(drive_lower_ff))))
      else $error("drive outside its limits");

   // Loading the result register presents the held drive on the next cycle.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_tvalid && rsp_tdata == $past(held_drive_ff)))
      else $error("result register not loaded with held drive");

endmodule
